/* design/bole_pkg.sv */
// ----------------------------------------------------------------------------
// bole_pkg
// Request and status codes, and the control struct that the sequencer
// broadcasts to every list cell.
// ----------------------------------------------------------------------------
package bole_pkg;

    localparam int VALUE_W  = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_DUMP   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic             cmp_en;
        logic [REQ_W-1:0] req_type;
        logic             shift_en;
        logic             dump_en;
    } cell_ctrl_t;

endpackage

/* design/bole_cell.sv */
// ----------------------------------------------------------------------------
// bole_cell
// One list position: holds an entry, compares it against the request value
// and moves entries to or from its neighbors on update and dump.
// ----------------------------------------------------------------------------
module bole_cell
(
    input  logic                                     clk,
    input  bole_pkg::cell_ctrl_t                     ctrl,
    input  logic                                     occ,
    input  logic                                     is_tail,
    input  logic signed [bole_pkg::VALUE_W-1:0]      req_value,
    input  logic signed [bole_pkg::VALUE_W-1:0]      left_value,
    input  logic signed [bole_pkg::VALUE_W-1:0]      right_value,
    input  logic signed [bole_pkg::VALUE_W-1:0]      head_value,
    input  logic                                     hit_in,
    output logic                                     hit_out,
    output logic signed [bole_pkg::VALUE_W-1:0]      cell_value
);

    logic signed [bole_pkg::VALUE_W-1:0] value_reg;
    logic signed [bole_pkg::VALUE_W-1:0] value_next;
    logic                                flag_reg;
    logic                                flag_next;

    // flag marks where the list opens (append, insert) or closes (delete)
    always_comb
    begin
        flag_next = flag_reg;
        if (ctrl.cmp_en)
        begin
            if (!occ)
            begin
                flag_next = (ctrl.req_type != bole_pkg::REQ_DELETE);
            end
            else
            begin
                case (ctrl.req_type)
                    bole_pkg::REQ_INSERT: flag_next = (value_reg > req_value);
                    bole_pkg::REQ_DELETE: flag_next = (value_reg == req_value);
                    default:              flag_next = 1'b0;
                endcase
            end
        end
    end

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.shift_en)
        begin
            if (ctrl.req_type == bole_pkg::REQ_DELETE)
            begin
                if (hit_in || flag_reg)
                begin
                    value_next = right_value;
                end
            end
            else if (hit_in)
            begin
                value_next = left_value;
            end
            else if (flag_reg)
            begin
                value_next = req_value;
            end
        end
        else if (ctrl.dump_en)
        begin
            // rotate the occupied part by one so the head comes out each cycle that dump_en is set
            value_next = is_tail ? head_value : right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        flag_reg  <= flag_next;
    end

    assign hit_out    = hit_in | flag_reg;
    assign cell_value = value_reg;

endmodule

/* design/bounded_ordered_list_engine.sv */
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine
// Ordered list of up to CAPACITY signed entries kept in a row of cells.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall, req_type, value): one request per item.
// Requests: append at tail, sorted insert, delete first equal, dump all.
// Output channel (out_valid / out_stall): one result item per update, one
// per entry for a dump (last marks the final one), one item for an empty dump.
// Update: accepted item is compared in every cell in the next cycle; then,
// once the output register is free, the cells shift and the result is
// registered, and a new request is taken as the result is written.
// Dump: the cell row rotates once per result, one result per cycle while the
// output register is free. A stalled receiver holds the output register; the
// sequencer then waits with the cells untouched until the register frees up.
// Reset clears the entry count, the sequencer and the output valid; entry
// values are unknown until written but only occupied cells are ever read.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine
#(
    parameter int CAPACITY = 16
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [bole_pkg::REQ_W-1:0]              req_type,
    input  logic signed [bole_pkg::VALUE_W-1:0]     value,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [bole_pkg::VALUE_W-1:0]     item_value,
    output logic [bole_pkg::STATUS_W-1:0]           status,
    output logic [bole_pkg::COUNT_W-1:0]            entry_count,
    output logic                                    last
);

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_DUMP = 2'd3;

    logic [1:0]                          state_reg, state_next;
    logic [CW-1:0]                       count_reg, count_next;
    logic [CW-1:0]                       dump_idx_reg, dump_idx_next;
    logic [bole_pkg::REQ_W-1:0]          req_type_reg;
    logic signed [bole_pkg::VALUE_W-1:0] req_value_reg;

    logic                                out_valid_reg, out_valid_next;
    logic signed [bole_pkg::VALUE_W-1:0] item_value_reg, item_value_next;
    logic [bole_pkg::STATUS_W-1:0]       status_reg, status_next;
    logic [bole_pkg::COUNT_W-1:0]        entry_count_reg, entry_count_next;
    logic                                last_reg, last_next;

    logic                                accept;
    logic                                out_free;
    logic                                emit;
    logic                                full;
    logic                                found;
    logic                                do_upd;
    logic                                dump_last;
    logic [CW+bole_pkg::COUNT_W-1:0]     count_ext;
    bole_pkg::cell_ctrl_t                ctrl;

    logic signed [bole_pkg::VALUE_W-1:0] cell_value [CAPACITY];
    logic                                hit        [CAPACITY+1];

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == S_IDLE) || ((state_reg == S_UPD) && out_free));
    assign accept    = in_valid && !in_stall;
    assign full      = (count_reg == CW'(CAPACITY));
    assign found     = hit[CAPACITY];
    assign dump_last = (dump_idx_reg == count_reg - CW'(1));

    assign emit   = ((state_reg == S_UPD) || (state_reg == S_DUMP)) && out_free;
    assign do_upd = (state_reg == S_UPD) && out_free && found &&
                    !(full && (req_type_reg != bole_pkg::REQ_DELETE));

    always_comb
    begin
        ctrl.cmp_en   = (state_reg == S_CMP);
        ctrl.req_type = req_type_reg;
        ctrl.shift_en = do_upd;
        ctrl.dump_en  = (state_reg == S_DUMP) && out_free && (count_reg != '0);
    end

    assign hit[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [bole_pkg::VALUE_W-1:0] left_v;
            logic signed [bole_pkg::VALUE_W-1:0] right_v;

            if (gi == 0)
            begin : g_first
                assign left_v = req_value_reg;
            end
            else
            begin : g_mid_left
                assign left_v = cell_value[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_v = cell_value[gi];
            end
            else
            begin : g_mid_right
                assign right_v = cell_value[gi+1];
            end

            bole_cell u_cell
            (
                .clk         (clk),
                .ctrl        (ctrl),
                .occ         (CW'(gi) < count_reg),
                .is_tail     (count_reg == CW'(gi + 1)),
                .req_value   (req_value_reg),
                .left_value  (left_v),
                .right_value (right_v),
                .head_value  (cell_value[0]),
                .hit_in      (hit[gi]),
                .hit_out     (hit[gi+1]),
                .cell_value  (cell_value[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (do_upd)
        begin
            if (req_type_reg == bole_pkg::REQ_DELETE)
            begin
                count_next = count_reg - CW'(1);
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    assign count_ext = {{bole_pkg::COUNT_W{1'b0}}, count_next};

    always_comb
    begin
        state_next    = state_reg;
        dump_idx_next = dump_idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req_type == bole_pkg::REQ_DUMP) ? S_DUMP : S_CMP;
                end
                dump_idx_next = '0;
            end
            S_CMP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (out_free)
                begin
                    if (accept)
                    begin
                        state_next = (req_type == bole_pkg::REQ_DUMP) ? S_DUMP : S_CMP;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                dump_idx_next = '0;
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    dump_idx_next = dump_idx_reg + CW'(1);
                    if ((count_reg == '0) || dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next   = out_valid_reg && out_stall;
        item_value_next  = item_value_reg;
        status_next      = status_reg;
        entry_count_next = entry_count_reg;
        last_next        = last_reg;
        if (emit)
        begin
            out_valid_next   = 1'b1;
            entry_count_next = count_ext[bole_pkg::COUNT_W-1:0];
            if (state_reg == S_UPD)
            begin
                item_value_next = req_value_reg;
                last_next       = 1'b1;
                if (req_type_reg == bole_pkg::REQ_DELETE)
                begin
                    status_next = found ? bole_pkg::ST_OK : bole_pkg::ST_NOTFOUND;
                end
                else
                begin
                    status_next = full ? bole_pkg::ST_FULL : bole_pkg::ST_OK;
                end
            end
            else if (count_reg == '0)
            begin
                item_value_next = '0;
                status_next     = bole_pkg::ST_EMPTY;
                last_next       = 1'b1;
            end
            else
            begin
                item_value_next = cell_value[0];
                status_next     = bole_pkg::ST_OK;
                last_next       = dump_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_idx_reg  <= dump_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg  <= req_type;
            req_value_reg <= value;
        end
        item_value_reg  <= item_value_next;
        status_reg      <= status_next;
        entry_count_reg <= entry_count_next;
        last_reg        <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign item_value  = item_value_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;
    assign last        = last_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_CMP) || (state_reg == S_DUMP))
        else $error("accepted item did not start compare or dump");

    a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
        (do_upd && (req_type_reg == bole_pkg::REQ_DELETE)) |=>
            (count_reg == $past(count_reg) - CW'(1)))
        else $error("delete did not shrink the list by one");

    a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DUMP) && out_free && (count_reg != '0) && dump_last) |=>
            (state_reg == S_IDLE) && out_valid_reg && last_reg)
        else $error("dump did not end on its last entry");
`endif

endmodule
